// ----- rtl/ovc_pkg.sv -----
// ovc_pkg: types and constants for the overcurrent fault qualifier
// no dependencies; used by overcurrent_fault_qualifier
`default_nettype none

package ovc_pkg;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_CLR_FAULT = 2'd2,
        CMD_CLR_COUNT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CURRENT_LIMIT = 2'd0,
        REG_NOISE_TIME    = 2'd1,
        REG_REPEAT_LIMIT  = 2'd2,
        REG_WINDOW_TIME   = 2'd3
    } reg_idx_t;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [15:0] CURRENT_LIMIT_RST = 16'd65535;
    localparam logic [15:0] NOISE_TIME_RST    = 16'd100;
    localparam logic [7:0]  REPEAT_LIMIT_RST  = 8'd3;
    localparam logic [15:0] WINDOW_TIME_RST   = 16'd1000;

    localparam logic [7:0]  EVENTS_MAX = 8'd255;

endpackage

`default_nettype wire

// ----- rtl/overcurrent_fault_qualifier.sv -----
// overcurrent_fault_qualifier: over-current debounce, event counter and fault latch
// top level; depends on ovc_pkg for command codes, register indexes and reset values
//
// usage:
//   input channel  in_valid/in_stall carries cmd, current_ma, motion_idle
//   output channel out_valid/out_stall carries fault, fault_raised, event_count
//   a transfer happens on a rising edge with valid high and stall low
//   every input transfer gives exactly one output transfer, in order
//   each item passes the input register, then the state update and the result
//   register in one pass
//   throughput: one item per cycle while the receiver does not stall; the state
//   update is compares, two 16-bit decrements and some flag logic, done in the
//   cycle an item leaves the input register
//   when the receiver stalls, the result register holds and the input
//   register takes one more item, then in_stall rises until the result moves
//   reset (rst_n low, asynchronous) empties both registers, clears all timers,
//   counts and the fault, and loads the register defaults
//   configuration: apb port, registers at byte addresses 0, 4, 8, 12; write
//   only while no item is in flight
`default_nettype none

module overcurrent_fault_qualifier (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // apb configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ovc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ovc_pkg::DATA_W-1:0] pwdata,
    output logic      [ovc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [15:0]                current_ma,
    input  wire logic                       motion_idle,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            fault,
    output logic                            fault_raised,
    output logic      [7:0]                 event_count
);

    // configuration registers
    logic [15:0] current_limit_reg;
    logic [15:0] noise_time_reg;
    logic [7:0]  repeat_limit_reg;
    logic [15:0] window_time_reg;

    // qualifier state
    logic        fault_flag_reg, fault_flag_next;
    logic [15:0] noise_rem_reg, noise_rem_next;
    logic        noise_armed_reg, noise_armed_next;
    logic        noise_exp_reg, noise_exp_next;
    logic [7:0]  events_reg, events_next;
    logic [15:0] window_rem_reg, window_rem_next;
    logic        window_exp_reg, window_exp_next;

    // input register
    logic          in_vld_reg;
    ovc_pkg::cmd_t cmd_reg;
    logic [15:0]   cur_reg;
    logic          idle_reg;

    // result register
    logic       out_vld_reg;
    logic       fault_out_reg;
    logic       raised_out_reg;
    logic [7:0] count_out_reg;

    logic cfg_wr;
    logic advance;
    logic in_take;
    logic [7:0] events_inc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign advance = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_limit_reg <= ovc_pkg::CURRENT_LIMIT_RST;
            noise_time_reg    <= ovc_pkg::NOISE_TIME_RST;
            repeat_limit_reg  <= ovc_pkg::REPEAT_LIMIT_RST;
            window_time_reg   <= ovc_pkg::WINDOW_TIME_RST;
        end
        else if (cfg_wr)
        begin
            unique case (ovc_pkg::reg_idx_t'(paddr[3:2]))
                ovc_pkg::REG_CURRENT_LIMIT: current_limit_reg <= pwdata[15:0];
                ovc_pkg::REG_NOISE_TIME:    noise_time_reg    <= pwdata[15:0];
                ovc_pkg::REG_REPEAT_LIMIT:  repeat_limit_reg  <= pwdata[7:0];
                ovc_pkg::REG_WINDOW_TIME:   window_time_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ovc_pkg::reg_idx_t'(paddr[3:2]))
            ovc_pkg::REG_CURRENT_LIMIT: prdata = {16'd0, current_limit_reg};
            ovc_pkg::REG_NOISE_TIME:    prdata = {16'd0, noise_time_reg};
            ovc_pkg::REG_REPEAT_LIMIT:  prdata = {24'd0, repeat_limit_reg};
            ovc_pkg::REG_WINDOW_TIME:   prdata = {16'd0, window_time_reg};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= ovc_pkg::cmd_t'(cmd);
            cur_reg  <= current_ma;
            idle_reg <= motion_idle;
        end
    end

    // ---------------- state update ----------------
    // saturating increment for the event count
    assign events_inc = (events_reg != ovc_pkg::EVENTS_MAX) ? events_reg + 8'd1 : events_reg;

    always_comb
    begin
        fault_flag_next  = fault_flag_reg;
        noise_rem_next   = noise_rem_reg;
        noise_armed_next = noise_armed_reg;
        noise_exp_next   = noise_exp_reg;
        events_next      = events_reg;
        window_rem_next  = window_rem_reg;
        window_exp_next  = window_exp_reg;

        case (cmd_reg)
            ovc_pkg::CMD_SAMPLE:
            begin
                if (idle_reg)
                begin
                    if (cur_reg >= current_limit_reg)
                    begin
                        if (!fault_flag_reg)
                        begin
                            if (!noise_armed_reg)
                            begin
                                // zero noise time arms already expired
                                noise_armed_next = 1'b1;
                                noise_rem_next   = noise_time_reg;
                                noise_exp_next   = (noise_time_reg == 16'd0);
                            end
                            else if (noise_exp_reg)
                            begin
                                noise_rem_next   = 16'd0;
                                noise_armed_next = 1'b0;
                                if (events_inc >= repeat_limit_reg)
                                begin
                                    fault_flag_next = 1'b1;
                                    events_next     = 8'd0;
                                    window_rem_next = 16'd0;
                                end
                                else
                                begin
                                    events_next     = events_inc;
                                    window_rem_next = window_time_reg;
                                    window_exp_next = (window_time_reg == 16'd0);
                                end
                            end
                        end
                    end
                    else
                    begin
                        noise_rem_next   = 16'd0;
                        noise_armed_next = 1'b0;
                    end
                    // window expiry clears the count; expired flag of noise stays
                    if (window_exp_next)
                    begin
                        noise_rem_next   = 16'd0;
                        noise_armed_next = 1'b0;
                        events_next      = 8'd0;
                        window_rem_next  = 16'd0;
                        window_exp_next  = 1'b0;
                    end
                end
            end
            ovc_pkg::CMD_TICK:
            begin
                if (noise_rem_reg != 16'd0)
                begin
                    noise_rem_next = noise_rem_reg - 16'd1;
                    noise_exp_next = (noise_rem_reg == 16'd1);
                end
                if (window_rem_reg != 16'd0)
                begin
                    window_rem_next = window_rem_reg - 16'd1;
                    window_exp_next = (window_rem_reg == 16'd1);
                end
            end
            ovc_pkg::CMD_CLR_FAULT:
            begin
                fault_flag_next = 1'b0;
            end
            default:
            begin
                noise_rem_next   = 16'd0;
                noise_armed_next = 1'b0;
                events_next      = 8'd0;
                window_rem_next  = 16'd0;
                window_exp_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_flag_reg  <= 1'b0;
            noise_rem_reg   <= 16'd0;
            noise_armed_reg <= 1'b0;
            noise_exp_reg   <= 1'b0;
            events_reg      <= 8'd0;
            window_rem_reg  <= 16'd0;
            window_exp_reg  <= 1'b0;
        end
        else if (advance)
        begin
            fault_flag_reg  <= fault_flag_next;
            noise_rem_reg   <= noise_rem_next;
            noise_armed_reg <= noise_armed_next;
            noise_exp_reg   <= noise_exp_next;
            events_reg      <= events_next;
            window_rem_reg  <= window_rem_next;
            window_exp_reg  <= window_exp_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_out_reg  <= fault_flag_next;
            raised_out_reg <= fault_flag_next && !fault_flag_reg;
            count_out_reg  <= events_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign fault        = fault_out_reg;
    assign fault_raised = raised_out_reg;
    assign event_count  = count_out_reg;

endmodule

`default_nettype wire

// ----- rtl/ovc_checker.sv -----
// ovc_props: port-level assertions for overcurrent_fault_qualifier
// depends on nothing but the top level's ports; bound to it at the end of this file
`default_nettype none

module ovc_props (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       fault,
    input wire logic       fault_raised,
    input wire logic [7:0] event_count,
    input wire logic       in_valid,
    input wire logic       in_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fault)
            && $stable(fault_raised) && $stable(event_count))
        else $error("stalled result changed");

    // a newly raised fault is shown as latched
    a_raised_latched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_raised |-> fault)
        else $error("fault_raised without fault");

    // latching the fault empties the event count
    a_raised_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_raised |-> event_count == 8'd0)
        else $error("event count not cleared on fault");

    // a transfer into an empty block shows up as a result behind the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("result missing after input transfer");

endmodule

bind overcurrent_fault_qualifier ovc_props u_ovc_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fault        (fault),
    .fault_raised (fault_raised),
    .event_count  (event_count),
    .in_valid     (in_valid),
    .in_stall     (in_stall)
);

`default_nettype wire
